>>> hw/rtl/mcpg_pkg.sv
// Package: shared constants and types of the midpoint circle point generator.
`timescale 1ns / 1ps

package mcpg_pkg;

    // Geometry limits
    localparam int MAX_RADIUS   = 1023;
    localparam int OCTANT_DEPTH = 1024;
    localparam int ADDR_W       = $clog2(OCTANT_DEPTH);

    // Field widths
    localparam int RADIUS_W = 10;
    localparam int COORD_W  = 11;
    localparam int DEC_W    = 14;
    localparam int HEIGHT_W = 10;

    // Command codes on the request channel
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

    // Octant being emitted: live first octant, then seven replays in order
    typedef enum logic [2:0] {
        SEG_LIVE     = 3'd0,
        SEG_YX_REV   = 3'd1,
        SEG_YNX_FWD  = 3'd2,
        SEG_XNY_REV  = 3'd3,
        SEG_NXNY_FWD = 3'd4,
        SEG_NYNX_REV = 3'd5,
        SEG_NYX_FWD  = 3'd6,
        SEG_NXY_REV  = 3'd7
    } seg_t;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DEC_W-1:0]   dec_t;
    typedef logic [COORD_W-1:0]        count_t;
    typedef logic [HEIGHT_W-1:0]       height_t;
    typedef logic [ADDR_W-1:0]         addr_t;

endpackage

>>> hw/rtl/mcpg_if.sv
// Interfaces: request and point channels with valid/ready handshake.
`timescale 1ns / 1ps

interface mcpg_req_if;
    logic                             valid;
    logic                             ready;
    logic                             cmd;
    logic [mcpg_pkg::RADIUS_W-1:0]    radius;

    modport source (output valid, output cmd, output radius, input ready);
    modport sink   (input valid, input cmd, input radius, output ready);
endinterface

interface mcpg_pt_if;
    logic                 valid;
    logic                 ready;
    mcpg_pkg::coord_t     px;
    mcpg_pkg::coord_t     py;
    logic                 last;

    modport source (output valid, output px, output py, output last, input ready);
    modport sink   (input valid, input px, input py, input last, output ready);
endinterface

>>> hw/rtl/midpoint_circle_point_generator_core.sv
// A next-point request beat's point is registered in stage one, then in the output stage.
// Throughput: one request per cycle while the point side accepts; a radius r circle takes 8*(octant size) requests.
// The heights memory is read at acceptance; its registered data forms the points of the replay octants.
// A start beat or a request while idle gives no point.
// Reset clears the walk state and both pipeline stages; the heights memory is not cleared.
`timescale 1ns / 1ps

module midpoint_circle_point_generator_core (
    input  logic         clk,
    input  logic         rst_n,
    mcpg_req_if.sink     req,
    mcpg_pt_if.source    rsp
);

    // Walk state
    logic                  active_reg, active_next;
    mcpg_pkg::seg_t        seg_reg, seg_next;
    mcpg_pkg::count_t      idx_reg, idx_next;
    mcpg_pkg::count_t      count_reg, count_next;
    mcpg_pkg::coord_t      cur_x_reg, cur_x_next;
    mcpg_pkg::coord_t      cur_y_reg, cur_y_next;
    mcpg_pkg::dec_t        dec_reg, dec_next;

    // Stage one: point descriptor plus memory read data
    logic                  s1_valid_reg, s1_valid_next;
    mcpg_pkg::seg_t        s1_seg_reg;
    mcpg_pkg::coord_t      s1_a_reg;
    mcpg_pkg::coord_t      s1_y_reg;
    logic                  s1_last_reg;
    mcpg_pkg::height_t     rd_reg;

    // Output stage
    logic                  out_valid_reg, out_valid_next;
    mcpg_pkg::coord_t      px_reg, py_reg;
    logic                  last_reg;

    mcpg_pkg::height_t     heights [mcpg_pkg::OCTANT_DEPTH];

    logic                  req_fire;
    logic                  emit;
    logic                  mem_we;
    logic                  last_pt;
    logic                  s1_adv;
    mcpg_pkg::count_t      rep_i;
    mcpg_pkg::count_t      idx_inc;
    mcpg_pkg::addr_t       rd_addr;
    mcpg_pkg::coord_t      x_inc, y_dec;
    mcpg_pkg::dec_t        x_ext, y_ext;
    mcpg_pkg::coord_t      map_px, map_py, map_b;
    logic [mcpg_pkg::RADIUS_W-1:0] rad_sat;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_adv;
    assign req_fire  = req.valid && req.ready;

    // Replay index: odd octants run in reverse
    assign idx_inc = idx_reg + 1'b1;
    assign rep_i   = seg_reg[0] ? (count_reg - 1'b1 - idx_reg) : idx_reg;
    assign rd_addr = rep_i[mcpg_pkg::ADDR_W-1:0];
    assign x_inc   = cur_x_reg + mcpg_pkg::coord_t'(1);
    assign y_dec   = cur_y_reg - mcpg_pkg::coord_t'(1);
    assign x_ext   = mcpg_pkg::DEC_W'(cur_x_reg);
    assign y_ext   = mcpg_pkg::DEC_W'(cur_y_reg);
    assign rad_sat = (32'(req.radius) > 32'(mcpg_pkg::MAX_RADIUS))
                     ? mcpg_pkg::RADIUS_W'(mcpg_pkg::MAX_RADIUS) : req.radius;

    // Walk next state
    always_comb
    begin
        active_next = active_reg;
        seg_next    = seg_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        dec_next    = dec_reg;
        emit        = 1'b0;
        mem_we      = 1'b0;
        last_pt     = 1'b0;
        if (req_fire)
        begin
            if (req.cmd == mcpg_pkg::CMD_START)
            begin
                active_next = 1'b1;
                seg_next    = mcpg_pkg::SEG_LIVE;
                idx_next    = '0;
                count_next  = '0;
                cur_x_next  = '0;
                cur_y_next  = mcpg_pkg::coord_t'({1'b0, rad_sat});
                dec_next    = mcpg_pkg::dec_t'(3)
                              - (mcpg_pkg::dec_t'({1'b0, rad_sat}) <<< 1);
            end
            else if (active_reg)
            begin
                emit = 1'b1;
                if (seg_reg == mcpg_pkg::SEG_LIVE)
                begin
                    mem_we     = 1'b1;
                    cur_x_next = x_inc;
                    if (dec_reg < 0)
                    begin
                        dec_next = dec_reg + (x_ext <<< 2) + mcpg_pkg::dec_t'(6);
                    end
                    else
                    begin
                        dec_next   = dec_reg + ((x_ext - y_ext) <<< 2)
                                     + mcpg_pkg::dec_t'(10);
                        cur_y_next = y_dec;
                    end
                    if (cur_x_next > cur_y_next)
                    begin
                        count_next = mcpg_pkg::count_t'(cur_x_next);
                        seg_next   = mcpg_pkg::SEG_YX_REV;
                        idx_next   = '0;
                    end
                end
                else
                begin
                    idx_next = idx_inc;
                    if (idx_inc >= count_reg)
                    begin
                        idx_next = '0;
                        if (seg_reg == mcpg_pkg::SEG_NXY_REV)
                        begin
                            last_pt     = 1'b1;
                            active_next = 1'b0;
                            seg_next    = mcpg_pkg::SEG_LIVE;
                        end
                        else
                        begin
                            seg_next = mcpg_pkg::seg_t'(seg_reg + 3'd1);
                        end
                    end
                end
            end
        end
    end

    // Walk registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            seg_reg    <= mcpg_pkg::SEG_LIVE;
            idx_reg    <= '0;
            count_reg  <= '0;
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            dec_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            seg_reg    <= seg_next;
            idx_reg    <= idx_next;
            count_reg  <= count_next;
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            dec_reg    <= dec_next;
        end
    end

    // Heights memory: write live heights, read replay heights on each emitted beat
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            heights[cur_x_reg[mcpg_pkg::ADDR_W-1:0]] <= cur_y_reg[mcpg_pkg::HEIGHT_W-1:0];
        end
        if (emit)
        begin
            rd_reg <= heights[rd_addr];
        end
    end

    // Stage one control
    assign s1_valid_next = emit || (s1_valid_reg && !s1_adv);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Stage one payload: load on each emitted beat
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            s1_seg_reg  <= seg_reg;
            s1_a_reg    <= (seg_reg == mcpg_pkg::SEG_LIVE) ? cur_x_reg
                                                           : mcpg_pkg::coord_t'(rep_i);
            s1_y_reg    <= cur_y_reg;
            s1_last_reg <= last_pt;
        end
    end

    // Map the stored octant point onto the current octant
    assign map_b = mcpg_pkg::coord_t'({1'b0, rd_reg});

    always_comb
    begin
        case (s1_seg_reg)
            mcpg_pkg::SEG_LIVE:
            begin
                map_px = s1_a_reg;
                map_py = s1_y_reg;
            end
            mcpg_pkg::SEG_YX_REV:
            begin
                map_px = map_b;
                map_py = s1_a_reg;
            end
            mcpg_pkg::SEG_YNX_FWD:
            begin
                map_px = map_b;
                map_py = -s1_a_reg;
            end
            mcpg_pkg::SEG_XNY_REV:
            begin
                map_px = s1_a_reg;
                map_py = -map_b;
            end
            mcpg_pkg::SEG_NXNY_FWD:
            begin
                map_px = -s1_a_reg;
                map_py = -map_b;
            end
            mcpg_pkg::SEG_NYNX_REV:
            begin
                map_px = -map_b;
                map_py = -s1_a_reg;
            end
            mcpg_pkg::SEG_NYX_FWD:
            begin
                map_px = -map_b;
                map_py = s1_a_reg;
            end
            mcpg_pkg::SEG_NXY_REV:
            begin
                map_px = -s1_a_reg;
                map_py = map_b;
            end
            default:
            begin
                map_px = s1_a_reg;
                map_py = s1_y_reg;
            end
        endcase
    end

    // Output stage control
    assign out_valid_next = s1_adv || (out_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload: advance from stage one
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            px_reg   <= map_px;
            py_reg   <= map_py;
            last_reg <= s1_last_reg;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.px    = px_reg;
    assign rsp.py    = py_reg;
    assign rsp.last  = last_reg;

    // Idle walk always sits on the live octant
    assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> seg_reg == mcpg_pkg::SEG_LIVE)
        else $error("idle walk left on a replay octant");

    // Live octant stays on or below the diagonal
    assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && seg_reg == mcpg_pkg::SEG_LIVE) |-> cur_x_reg <= cur_y_reg)
        else $error("live octant crossed the diagonal");

    // Replay position stays inside the octant
    assert property (@(posedge clk) disable iff (!rst_n)
        seg_reg != mcpg_pkg::SEG_LIVE |-> (idx_reg < count_reg && count_reg != '0))
        else $error("replay index out of octant");

    // A stalled stage one beat is kept
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> s1_valid_reg)
        else $error("stage one beat dropped");

    // Input taken only when stage one can hold the beat
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!s1_valid_reg || s1_adv))
        else $error("stage one overrun");

endmodule

>>> dv/mcpg_point_checker.sv
// Point checker: follows the circle walk from request beats and checks every point beat.
`timescale 1ns / 1ps

module mcpg_point_checker (
    input  logic clk,
    input  logic rst_n,
    mcpg_req_if  req_mon,
    mcpg_pt_if   pt_mon,
    output int   fail_count,
    output int   pending
);
    import mcpg_pkg::*;

    typedef struct {
        coord_t px;
        coord_t py;
        logic   last;
    } point_t;

    // Shadow copy of the walk state
    height_t height_mem [OCTANT_DEPTH];
    int      walk_x;
    int      walk_y;
    int      walk_d;
    int      oct_len;
    int      seg_pos;
    seg_t    seg;
    logic    circle_on;

    point_t  points_due [$];
    int      errors;

    // Advance the walk by one accepted request beat; queue the point it yields
    task automatic advance_walk(input logic cmd, input logic [RADIUS_W-1:0] radius);
        int     r;
        int     idx;
        int     a;
        int     b;
        int     px_i;
        int     py_i;
        point_t pt;
        pt.last = 1'b0;
        if (cmd == CMD_START)
        begin
            r = int'(radius);
            if (r > MAX_RADIUS)
                r = MAX_RADIUS;
            walk_x    = 0;
            walk_y    = r;
            walk_d    = 3 - 2 * r;
            oct_len   = 0;
            seg       = SEG_LIVE;
            seg_pos   = 0;
            circle_on = 1'b1;
            return;
        end
        // Drop requests outside an active circle
        if (!circle_on)
            return;
        if (seg == SEG_LIVE)
        begin
            px_i = walk_x;
            py_i = walk_y;
            height_mem[walk_x[ADDR_W-1:0]] = walk_y[HEIGHT_W-1:0];
            if (walk_d < 0)
            begin
                walk_d = walk_d + 4 * walk_x + 6;
            end
            else
            begin
                walk_d = walk_d + 4 * (walk_x - walk_y) + 10;
                walk_y = walk_y - 1;
            end
            walk_x = walk_x + 1;
            if (walk_x > walk_y)
            begin
                oct_len = walk_x;
                seg     = SEG_YX_REV;
                seg_pos = 0;
            end
        end
        else
        begin
            // Odd octants replay the store backward, even ones forward
            idx = seg[0] ? (oct_len - 1 - seg_pos) : seg_pos;
            a   = idx;
            b   = int'(height_mem[idx[ADDR_W-1:0]]);
            case (seg)
                SEG_YX_REV:   {px_i, py_i} = {b, a};
                SEG_YNX_FWD:  {px_i, py_i} = {b, -a};
                SEG_XNY_REV:  {px_i, py_i} = {a, -b};
                SEG_NXNY_FWD: {px_i, py_i} = {-a, -b};
                SEG_NYNX_REV: {px_i, py_i} = {-b, -a};
                SEG_NYX_FWD:  {px_i, py_i} = {-b, a};
                default:      {px_i, py_i} = {-a, b};
            endcase
            seg_pos = seg_pos + 1;
            if (seg_pos >= oct_len)
            begin
                seg_pos = 0;
                if (seg == SEG_NXY_REV)
                begin
                    pt.last   = 1'b1;
                    circle_on = 1'b0;
                    seg       = SEG_LIVE;
                end
                else
                begin
                    seg = seg_t'(seg + 1);
                end
            end
        end
        pt.px = px_i[COORD_W-1:0];
        pt.py = py_i[COORD_W-1:0];
        points_due = {points_due, pt};
    endtask

    // Report one mismatch
    task automatic flag(input string what, input int want, input int got);
        errors = errors + 1;
        $display("%0t: %s expected %0d got %0d", $time, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        point_t want;
        if (!rst_n)
        begin
            walk_x    = 0;
            walk_y    = 0;
            walk_d    = 0;
            oct_len   = 0;
            seg_pos   = 0;
            seg       = SEG_LIVE;
            circle_on = 1'b0;
            errors    = 0;
            points_due.delete();
        end
        else
        begin
            // Check each point beat against the oldest expected point
            if (pt_mon.valid && pt_mon.ready)
            begin
                if (points_due.size() == 0)
                begin
                    flag("point with none pending, px", 0, int'(pt_mon.px));
                end
                else
                begin
                    want = points_due.pop_front();
                    if (pt_mon.px !== want.px)
                        flag("px", int'(want.px), int'(pt_mon.px));
                    if (pt_mon.py !== want.py)
                        flag("py", int'(want.py), int'(pt_mon.py));
                    if (pt_mon.last !== want.last)
                        flag("last", int'(want.last), int'(pt_mon.last));
                end
            end
            if (req_mon.valid && req_mon.ready)
                advance_walk(req_mon.cmd, req_mon.radius);
        end
        fail_count <= errors;
        pending    <= points_due.size();
    end

endmodule

>>> dv/midpoint_circle_point_generator_core_test.sv
// Testbench top: clock, reset, request stimulus, point stall pattern and verdict.
`timescale 1ns / 1ps

module midpoint_circle_point_generator_core_test;
    import mcpg_pkg::*;

    localparam int IDLE_LIMIT = 5000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    int   burst_left;
    int   sent_items;
    logic long_hold_arm;
    logic long_hold_done;
    int   hold_left;
    int   mode_left;
    int   stall_mode;

    mcpg_req_if req_bus ();
    mcpg_pt_if  pt_bus ();

    midpoint_circle_point_generator_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (pt_bus)
    );

    mcpg_point_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_mon    (req_bus),
        .pt_mon     (pt_bus),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Number of first-octant points for a radius
    function automatic int octant_points(input int r);
        int x;
        int y;
        int d;
        x = 0;
        y = r;
        d = 3 - 2 * r;
        while (x <= y)
        begin
            if (d < 0)
            begin
                d = d + 4 * x + 6;
            end
            else
            begin
                d = d + 4 * (x - y) + 10;
                y = y - 1;
            end
            x = x + 1;
        end
        return x;
    endfunction

    // Offer one request beat in bursts with random gaps; return at acceptance
    task automatic offer(input logic cmd, input logic [RADIUS_W-1:0] radius);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                req_bus.valid  <= 1'b0;
                req_bus.radius <= RADIUS_W'($urandom);
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 30);
        end
        req_bus.valid  <= 1'b1;
        req_bus.cmd    <= cmd;
        req_bus.radius <= radius;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        burst_left = burst_left - 1;
        sent_items = sent_items + 1;
    endtask

    // Hold the request side until every expected point has arrived
    task automatic drain();
        req_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Point receiver: stall patterns of varying density, plus one long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                hold_left    = hold_left - 1;
                pt_bus.ready <= 1'b0;
            end
            else if (long_hold_arm && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                hold_left      = 300;
                pt_bus.ready   <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode_left  = $urandom_range(10, 80);
                    stall_mode = $urandom_range(0, 2);
                end
                else
                begin
                    mode_left = mode_left - 1;
                end
                case (stall_mode)
                    0:       pt_bus.ready <= 1'b1;
                    1:       pt_bus.ready <= ($urandom_range(0, 3) != 0);
                    default: pt_bus.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge clk)
    begin
        if ((req_bus.valid && req_bus.ready) || (pt_bus.valid && pt_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        int   r;
        int   n;
        int   pick;
        logic drained;
        req_bus.valid  = 1'b0;
        req_bus.cmd    = CMD_NEXT;
        req_bus.radius = '0;
        pt_bus.ready   = 1'b0;
        rst_n          = 1'b0;
        long_hold_arm  = 1'b0;
        long_hold_done = 1'b0;
        hold_left      = 0;
        mode_left      = 0;
        stall_mode     = 0;
        idle_cycles    = 0;
        burst_left     = 0;
        sent_items     = 0;
        drained        = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Request while idle gives nothing
        offer(CMD_NEXT, '0);
        // Zero radius: eight origin points, then an idle request
        offer(CMD_START, '0);
        repeat (8) offer(CMD_NEXT, RADIUS_W'($urandom));
        offer(CMD_NEXT, '1);
        // Largest radius, abandoned in the live octant
        offer(CMD_START, '1);
        repeat (2) offer(CMD_NEXT, '0);
        // Restart mid-circle, run into the replays, restart again
        offer(CMD_START, 10'd1);
        repeat (5) offer(CMD_NEXT, 10'h2AA);
        offer(CMD_START, 10'd0);
        repeat (2) offer(CMD_NEXT, 10'h155);

        // Random circles; the point side takes one long hold-off early on
        long_hold_arm <= 1'b1;
        while (sent_items < 1550)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                // Whole circle, mostly small
                r = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120)
                                                : $urandom_range(0, 40);
                offer(CMD_START, RADIUS_W'(r));
                n = 8 * octant_points(r);
                repeat (n) offer(CMD_NEXT, RADIUS_W'($urandom));
                if ($urandom_range(0, 2) == 0)
                    repeat ($urandom_range(1, 2)) offer(CMD_NEXT, RADIUS_W'($urandom));
            end
            else if (pick < 90)
            begin
                // Any radius, cut short by the next start
                offer(CMD_START, RADIUS_W'($urandom_range(0, 1023)));
                repeat ($urandom_range(0, 40)) offer(CMD_NEXT, RADIUS_W'($urandom));
            end
            else
            begin
                // Stray requests
                repeat ($urandom_range(1, 4)) offer(CMD_NEXT, RADIUS_W'($urandom));
            end
            if (!drained && sent_items >= 800)
            begin
                drained = 1'b1;
                drain();
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
